// File: sv/rcd_pkg.sv
package rcd_pkg;

    // Field widths fixed by the deck interface.
    localparam int FUNC_W   = 2;
    localparam int ID_W     = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 7;

    // Default deck capacity.
    localparam int DECK_DEPTH_DEFAULT = 64;

    // Operation codes.
    typedef enum logic [FUNC_W-1:0] {
        FUNC_PUSH     = 2'd0,
        FUNC_POP      = 2'd1,
        FUNC_TOP2BOT  = 2'd2,
        FUNC_BOT2TOP  = 2'd3
    } func_t;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        STATUS_DONE  = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_FULL  = 2'd2
    } status_t;

    // Per-operation control carried from the pointer logic to the data stage.
    typedef struct packed {
        logic    rd;     // store read issued
        logic    wr;     // store write pending
        logic    wr_id;  // write data comes from the pushed id
        logic    give;   // read value is returned as removed_id
        status_t status;
    } ctl_t;

endpackage

// File: sv/rcd_ctrl.sv
module rcd_ctrl
    import rcd_pkg::*;
#(
    parameter int DECK_DEPTH = DECK_DEPTH_DEFAULT,
    localparam int IDX_W = $clog2(DECK_DEPTH),
    localparam int CNT_W = $clog2(DECK_DEPTH + 1)
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             accept,
    input  func_t            func,
    output ctl_t             ctl,
    output logic [IDX_W-1:0] rd_addr,
    output logic [IDX_W-1:0] wr_addr,
    output logic [CNT_W-1:0] count_after
);

    localparam int SUM_W = CNT_W + 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DECK_DEPTH - 1);
    localparam logic [SUM_W-1:0] DEPTH_S  = SUM_W'(DECK_DEPTH);
    localparam logic [CNT_W-1:0] DEPTH_C  = CNT_W'(DECK_DEPTH);

    logic [IDX_W-1:0] top_reg;
    logic [IDX_W-1:0] top_next;
    logic [CNT_W-1:0] size_reg;
    logic [CNT_W-1:0] size_next;

    logic [IDX_W-1:0] top_inc;
    logic [IDX_W-1:0] top_dec;
    logic [SUM_W-1:0] sum;
    logic [SUM_W-1:0] sum_m1;
    logic [SUM_W-1:0] below_wrap;
    logic [SUM_W-1:0] bottom_wrap;
    logic             empty;
    logic             full;
    logic             many;

    // Neighbor slots of the top card, with wraparound.
    assign top_inc = (top_reg == LAST_IDX) ? '0 : top_reg + IDX_W'(1);
    assign top_dec = (top_reg == '0) ? LAST_IDX : top_reg - IDX_W'(1);

    // Slot just past the bottom card, and the bottom card itself.
    assign sum         = SUM_W'(top_reg) + SUM_W'(size_reg);
    assign sum_m1      = sum - SUM_W'(1);
    assign below_wrap  = (sum >= DEPTH_S) ? sum - DEPTH_S : sum;
    assign bottom_wrap = (sum_m1 >= DEPTH_S) ? sum_m1 - DEPTH_S : sum_m1;

    assign empty = (size_reg == '0);
    assign full  = (size_reg == DEPTH_C);
    assign many  = (size_reg > CNT_W'(1));

    // Decode the operation against the current deck.
    always_comb
    begin
        ctl        = '{rd: 1'b0, wr: 1'b0, wr_id: 1'b0, give: 1'b0, status: STATUS_DONE};
        rd_addr    = top_reg;
        wr_addr    = top_dec;
        top_next   = top_reg;
        size_next  = size_reg;
        case (func)
            FUNC_PUSH:
            begin
                if (full)
                begin
                    ctl.status = STATUS_FULL;
                end
                else
                begin
                    ctl.wr    = 1'b1;
                    ctl.wr_id = 1'b1;
                    top_next  = top_dec;
                    size_next = size_reg + CNT_W'(1);
                end
            end
            FUNC_POP:
            begin
                if (empty)
                begin
                    ctl.status = STATUS_EMPTY;
                end
                else
                begin
                    ctl.rd    = 1'b1;
                    ctl.give  = 1'b1;
                    top_next  = top_inc;
                    size_next = size_reg - CNT_W'(1);
                end
            end
            FUNC_TOP2BOT:
            begin
                if (empty)
                begin
                    ctl.status = STATUS_EMPTY;
                end
                else if (many)
                begin
                    ctl.rd   = 1'b1;
                    ctl.wr   = 1'b1;
                    wr_addr  = below_wrap[IDX_W-1:0];
                    top_next = top_inc;
                end
            end
            FUNC_BOT2TOP:
            begin
                if (empty)
                begin
                    ctl.status = STATUS_EMPTY;
                end
                else if (many)
                begin
                    ctl.rd   = 1'b1;
                    ctl.wr   = 1'b1;
                    rd_addr  = bottom_wrap[IDX_W-1:0];
                    top_next = top_dec;
                end
            end
            default:
            begin
                ctl.status = STATUS_DONE;
            end
        endcase
    end

    assign count_after = size_next;

    // Pointer state advances once per accepted beat.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            top_reg  <= '0;
            size_reg <= '0;
        end
        else if (accept)
        begin
            top_reg  <= top_next;
            size_reg <= size_next;
        end
    end

endmodule

// File: sv/rcd_store.sv
module rcd_store
    import rcd_pkg::*;
#(
    parameter int DECK_DEPTH = DECK_DEPTH_DEFAULT,
    localparam int IDX_W = $clog2(DECK_DEPTH)
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             rd_en,
    input  logic [IDX_W-1:0] rd_addr,
    input  logic             wr_en,
    input  logic [IDX_W-1:0] wr_addr,
    input  logic [ID_W-1:0]  wr_data,
    output logic [ID_W-1:0]  rd_data
);

    logic [ID_W-1:0] mem [DECK_DEPTH];
    logic [ID_W-1:0] rdata_reg;
    logic [ID_W-1:0] fwd_data_reg;
    logic            fwd_reg;
    logic            fwd_next;

    // A read that meets a write to the same slot at the same edge takes the new data.
    assign fwd_next = rd_en & wr_en & (rd_addr == wr_addr);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rdata_reg    <= mem[rd_addr];
            fwd_data_reg <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_reg <= 1'b0;
        end
        else if (rd_en)
        begin
            fwd_reg <= fwd_next;
        end
    end

    assign rd_data = fwd_reg ? fwd_data_reg : rdata_reg;

endmodule

// File: sv/rotating_card_deque.sv
// Channel  Direction  Handshake            Fields
// input    in         in_valid / in_stall  func, card_id
// output   out        out_valid/out_stall  status, removed_id, card_count
//
// One beat enters per cycle while the input is not stalled; its result passes through
// the data stage and then the output register before it is offered.
// The pointer update is done at acceptance and the store read is registered; the
// store write (push id or rotated card) happens as the beat moves into the output
// register, with a bypass covering a read of the slot being written at that edge.
// Reset clears the pointers and pipeline valids; the store itself is not cleared.
// The input stalls only while both the data stage and the output register are full and the output is stalled.
module rotating_card_deque
    import rcd_pkg::*;
#(
    parameter int DECK_DEPTH = DECK_DEPTH_DEFAULT
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [FUNC_W-1:0]          func,
    input  logic signed [ID_W-1:0]     card_id,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [STATUS_W-1:0]        status,
    output logic signed [ID_W-1:0]     removed_id,
    output logic [COUNT_W-1:0]         card_count
);

    localparam int IDX_W = $clog2(DECK_DEPTH);
    localparam int CNT_W = $clog2(DECK_DEPTH + 1);
    localparam int EXT_W = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;

    logic             accept;
    logic             s1_adv;
    ctl_t             ctl;
    logic [IDX_W-1:0] rd_addr;
    logic [IDX_W-1:0] wr_addr;
    logic [CNT_W-1:0] count_after;

    logic             s1_valid_reg;
    ctl_t             s1_ctl_reg;
    logic [IDX_W-1:0] s1_waddr_reg;
    logic [ID_W-1:0]  s1_id_reg;
    logic [CNT_W-1:0] s1_count_reg;

    logic [ID_W-1:0]  read_val;
    logic [ID_W-1:0]  store_wdata;
    logic             store_we;
    logic [EXT_W-1:0] count_ext;

    logic                out_valid_reg;
    logic [STATUS_W-1:0] status_reg;
    logic [ID_W-1:0]     removed_reg;
    logic [COUNT_W-1:0]  count_reg;

    // Handshake: the data stage moves on when the output register is free or its beat is being taken.
    assign s1_adv   = s1_valid_reg & (~out_valid_reg | ~out_stall);
    assign in_stall = s1_valid_reg & ~s1_adv;
    assign accept   = in_valid & ~in_stall;

    rcd_ctrl #(
        .DECK_DEPTH(DECK_DEPTH)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .func       (func_t'(func)),
        .ctl        (ctl),
        .rd_addr    (rd_addr),
        .wr_addr    (wr_addr),
        .count_after(count_after)
    );

    // Store write for the beat leaving the data stage.
    assign store_we    = s1_adv & s1_ctl_reg.wr;
    assign store_wdata = s1_ctl_reg.wr_id ? s1_id_reg : read_val;

    rcd_store #(
        .DECK_DEPTH(DECK_DEPTH)
    ) u_store (
        .clk    (clk),
        .rst_n  (rst_n),
        .rd_en  (accept & ctl.rd),
        .rd_addr(rd_addr),
        .wr_en  (store_we),
        .wr_addr(s1_waddr_reg),
        .wr_data(store_wdata),
        .rd_data(read_val)
    );

    // Data stage valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    // Data stage payload.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_ctl_reg <= '{rd: 1'b0, wr: 1'b0, wr_id: 1'b0, give: 1'b0, status: STATUS_DONE};
        end
        else if (accept)
        begin
            s1_ctl_reg <= ctl;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_waddr_reg <= wr_addr;
            s1_id_reg    <= card_id;
            s1_count_reg <= count_after;
        end
    end

    assign count_ext = EXT_W'(s1_count_reg);

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_adv)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (~out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            status_reg  <= s1_ctl_reg.status;
            removed_reg <= s1_ctl_reg.give ? read_val : '0;
            count_reg   <= count_ext[COUNT_W-1:0];
        end
    end

    assign out_valid  = out_valid_reg;
    assign status     = status_reg;
    assign removed_id = removed_reg;
    assign card_count = count_reg;

`ifndef SYNTHESIS
    // A store write only happens as the beat moves into the output register.
    a_write_on_advance: assert property (@(posedge clk) disable iff (!rst_n)
        store_we |-> (!out_valid_reg || !out_stall))
        else $error("store written while data stage is held");

    // A full report means the deck really holds its capacity.
    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s1_ctl_reg.status == STATUS_FULL)
            |-> (s1_count_reg == CNT_W'(DECK_DEPTH)))
        else $error("full status with a deck below capacity");

    // An empty report means no cards remain and nothing is returned.
    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s1_ctl_reg.status == STATUS_EMPTY)
            |-> (s1_count_reg == '0 && !s1_ctl_reg.give && !s1_ctl_reg.wr))
        else $error("empty status with cards in the deck");

    // An accepted beat appears at the output on the cycle after it advances.
    a_advance_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        s1_adv |=> out_valid_reg)
        else $error("advanced beat missing from output register");
`endif

endmodule

// File: tb/card_deck_checker.sv
`timescale 1ns / 100ps

// Watches both channels of the deck, mirrors the deck contents and compares
// every result beat against the mirrored outcome of its operation.
module card_deck_checker
    import rcd_pkg::*;
#(
    parameter int DEPTH = DECK_DEPTH_DEFAULT
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  logic                   in_stall,
    input  logic [FUNC_W-1:0]      func,
    input  logic signed [ID_W-1:0] card_id,
    input  logic                   out_valid,
    input  logic                   out_stall,
    input  logic [STATUS_W-1:0]    status,
    input  logic signed [ID_W-1:0] removed_id,
    input  logic [COUNT_W-1:0]     card_count,
    output int                     fail_count,
    output int                     pending
);

    localparam int PTR_W = $clog2(DEPTH);

    typedef struct {
        status_t               status;
        logic signed [ID_W-1:0] removed;
        logic [COUNT_W-1:0]     count;
    } deck_result_t;

    // Mirror of the deck: card ids, index of the top card and card count.
    logic signed [ID_W-1:0] deck_mem [DEPTH];
    logic [PTR_W-1:0]       top_ptr;
    logic [COUNT_W-1:0]     deck_cnt;

    deck_result_t due_results [$];
    int           miscompares;

    // Applies one operation to the mirrored deck and returns its result.
    task automatic deck_apply(input func_t op, input logic signed [ID_W-1:0] id,
                              output deck_result_t res);
        logic signed [ID_W-1:0] moved;
        logic [PTR_W-1:0]       bottom;
        res.status  = STATUS_DONE;
        res.removed = '0;
        case (op)
            FUNC_PUSH:
            begin
                if (deck_cnt == DEPTH)
                begin
                    res.status = STATUS_FULL;
                end
                else
                begin
                    top_ptr           = top_ptr - 1'b1;
                    deck_mem[top_ptr] = id;
                    deck_cnt          = deck_cnt + 1'b1;
                end
            end
            FUNC_POP:
            begin
                if (deck_cnt == 0)
                begin
                    res.status = STATUS_EMPTY;
                end
                else
                begin
                    res.removed = deck_mem[top_ptr];
                    top_ptr     = top_ptr + 1'b1;
                    deck_cnt    = deck_cnt - 1'b1;
                end
            end
            FUNC_TOP2BOT:
            begin
                if (deck_cnt == 0)
                begin
                    res.status = STATUS_EMPTY;
                end
                else if (deck_cnt > 1)
                begin
                    moved            = deck_mem[top_ptr];
                    top_ptr          = top_ptr + 1'b1;
                    bottom           = top_ptr + deck_cnt[PTR_W-1:0] - 1'b1;
                    deck_mem[bottom] = moved;
                end
            end
            default:
            begin
                if (deck_cnt == 0)
                begin
                    res.status = STATUS_EMPTY;
                end
                else if (deck_cnt > 1)
                begin
                    bottom            = top_ptr + deck_cnt[PTR_W-1:0] - 1'b1;
                    moved             = deck_mem[bottom];
                    top_ptr           = top_ptr - 1'b1;
                    deck_mem[top_ptr] = moved;
                end
            end
        endcase
        res.count = deck_cnt;
    endtask

    // Results are retired before new operations are predicted, since a result
    // can never belong to a beat accepted at the same edge.
    always @(posedge clk or negedge rst_n)
    begin
        deck_result_t exp_res;
        deck_result_t new_res;
        if (!rst_n)
        begin
            top_ptr     = '0;
            deck_cnt    = '0;
            miscompares = 0;
            due_results.delete();
            fail_count <= 0;
            pending    <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (due_results.size() == 0)
                begin
                    miscompares++;
                    if (miscompares <= 10)
                        $display("%0t: result beat with nothing expected: status %0d id %0d count %0d",
                                 $realtime, status, removed_id, card_count);
                end
                else
                begin
                    exp_res = due_results.pop_front();
                    if (status !== exp_res.status || removed_id !== exp_res.removed
                        || card_count !== exp_res.count)
                    begin
                        miscompares++;
                        if (miscompares <= 10)
                            $display({"%0t: deck mismatch: expected status %0d id %0d count %0d,",
                                      " got status %0d id %0d count %0d"},
                                     $realtime, exp_res.status, exp_res.removed, exp_res.count,
                                     status, removed_id, card_count);
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                deck_apply(func_t'(func), card_id, new_res);
                due_results.push_back(new_res);
            end
            fail_count <= miscompares;
            pending    <= due_results.size();
        end
    end

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import rcd_pkg::*;

    localparam int DEPTH       = DECK_DEPTH_DEFAULT;
    localparam int ITEM_TARGET = 1300;
    localparam int QUIET_LIMIT = 4000;

    // Kinds of operation mix used by the random part.
    typedef enum int {
        MIX_FILL,
        MIX_DRAIN,
        MIX_PUSHY,
        MIX_ROTATE,
        MIX_ANY
    } op_mix_t;

    logic                   clk;
    logic                   rst_n      = 1'b0;
    logic                   in_valid   = 1'b0;
    logic                   in_stall;
    logic [FUNC_W-1:0]      func       = FUNC_PUSH;
    logic signed [ID_W-1:0] card_id    = '0;
    logic                   out_valid;
    logic                   out_stall  = 1'b0;
    logic [STATUS_W-1:0]    status;
    logic signed [ID_W-1:0] removed_id;
    logic [COUNT_W-1:0]     card_count;
    logic                   calm       = 1'b0;
    int                     fail_count;
    int                     pending;
    int                     quiet_cycles = 0;
    int                     items_sent   = 0;

    rotating_card_deque #(.DECK_DEPTH(DEPTH)) u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .func       (func),
        .card_id    (card_id),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .status     (status),
        .removed_id (removed_id),
        .card_count (card_count)
    );

    card_deck_checker #(.DEPTH(DEPTH)) u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .func       (func),
        .card_id    (card_id),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .status     (status),
        .removed_id (removed_id),
        .card_count (card_count),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // The receiver stalls at random, except inside the calm window.
    always @(posedge clk)
    begin
        out_stall <= !calm && ($urandom_range(0, 99) < 20);
    end

    // Watchdog: ends the run when no beat moves on either channel for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("tb_top NOT OK");
                $finish;
            end
        end
    end

    // Offers one operation beat, with random idle cycles ahead of it, and
    // returns at the edge where it is accepted.
    task automatic send_op(input func_t op, input logic signed [ID_W-1:0] id);
        while (!calm && $urandom_range(0, 99) < 20)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        func     <= op;
        card_id  <= id;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        items_sent++;
    endtask

    // Holds the sender until every outstanding result has been returned.
    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    // Random id, with the extremes of the range now and then.
    function automatic logic signed [ID_W-1:0] pick_id();
        case ($urandom_range(0, 15))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return '0;
            3:       return '1;
            default: return $urandom;
        endcase
    endfunction

    // Picks an operation according to the current mix.
    function automatic func_t pick_op(input op_mix_t mix);
        int roll;
        roll = $urandom_range(0, 99);
        case (mix)
            MIX_PUSHY:
                return (roll < 60) ? FUNC_PUSH : (roll < 75) ? FUNC_POP :
                       (roll < 88) ? FUNC_TOP2BOT : FUNC_BOT2TOP;
            MIX_ROTATE:
                return (roll < 15) ? FUNC_PUSH : (roll < 25) ? FUNC_POP :
                       (roll < 62) ? FUNC_TOP2BOT : FUNC_BOT2TOP;
            default:
                return func_t'($urandom_range(0, 3));
        endcase
    endfunction

    initial
    begin
        op_mix_t mix;
        int      run_len;

        // Reset is held from the start and released at a clock edge.
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty deck: pop and both rotates report empty.
        send_op(FUNC_POP, pick_id());
        send_op(FUNC_TOP2BOT, pick_id());
        send_op(FUNC_BOT2TOP, pick_id());
        // A single card: rotates leave the deck as it is.
        send_op(FUNC_PUSH, 32'h7FFF_FFFF);
        send_op(FUNC_TOP2BOT, pick_id());
        send_op(FUNC_BOT2TOP, pick_id());
        send_op(FUNC_POP, pick_id());
        // Extreme ids, then rotations in both directions and a full drain.
        send_op(FUNC_PUSH, 32'h8000_0000);
        send_op(FUNC_PUSH, '0);
        send_op(FUNC_PUSH, '1);
        send_op(FUNC_PUSH, 32'h5A5A_A5A5);
        send_op(FUNC_TOP2BOT, pick_id());
        send_op(FUNC_BOT2TOP, pick_id());
        send_op(FUNC_BOT2TOP, pick_id());
        repeat (4) send_op(FUNC_POP, pick_id());
        send_op(FUNC_POP, pick_id());
        drain_results();

        // Random part: runs of one operation mix each.
        while (items_sent < ITEM_TARGET)
        begin
            calm <= (items_sent > 500 && items_sent < 750);
            mix  = op_mix_t'($urandom_range(0, 4));
            case (mix)
                MIX_FILL:
                begin
                    // More pushes than the deck holds, then work on a full deck.
                    repeat (DEPTH + 4) send_op(FUNC_PUSH, pick_id());
                    repeat (12) send_op(pick_op(MIX_ROTATE), pick_id());
                end
                MIX_DRAIN:
                begin
                    repeat (DEPTH + 4) send_op(FUNC_POP, pick_id());
                end
                default:
                begin
                    run_len = $urandom_range(20, 60);
                    repeat (run_len) send_op(pick_op(mix), pick_id());
                end
            endcase
            if (items_sent > 900 && items_sent < 1000)
                drain_results();
        end
        in_valid <= 1'b0;

        // Wait for the outstanding results, then a few cycles for strays.
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (fail_count == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule

// File: files.f
sv/rcd_pkg.sv
sv/rcd_ctrl.sv
sv/rcd_store.sv
sv/rotating_card_deque.sv
tb/card_deck_checker.sv
tb/tb_top.sv
